// ===== rtl/lcb_pkg.sv =====
// Shared types and constants for the LRU contact bucket.
// Used by lru_contact_bucket; no dependencies.
`default_nettype none

package lcb_pkg;

  localparam int MAX_SLOTS = 32;
  localparam int KEY_BITS  = 64;
  localparam int EP_BITS   = 48;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
  localparam int ENTRY_W   = KEY_BITS + EP_BITS;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] CAPACITY_RESET = CNT_W'(20);

  typedef enum logic [2:0] {
    CMD_ADD    = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_LOOKUP = 3'd2,
    CMD_OLDEST = 3'd3,
    CMD_RANGE  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_MISS = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAPACITY   = 2'd0,
    REG_RANGE_LOW  = 2'd1,
    REG_RANGE_HIGH = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OLDEST,
    ST_SHIFT,
    ST_FRONT,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/lcb_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module lcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lru_contact_bucket.sv =====
// LRU contact bucket: a recency-ordered table of up to MAX_SLOTS contacts held in
// one slot RAM (key and endpoint per slot, slot 0 newest). Lookup, remove and add
// walk the RAM one slot per cycle through its single read port: each scans from the
// front until the key matches or the last slot is reached, and a remove or add then
// moves the slots behind or in front of the match one place, one slot per cycle, and
// an add then writes the front slot. Oldest reads the last slot; range check and
// unused codes go straight to the result. One word is in flight at a time, and a
// finished result waits in the output register while the next word is taken. The
// RAM needs no clearing after reset: only slots below the occupancy, or the slot
// just vacated by a remove, are ever read.
// Depends on lcb_pkg and lcb_ram.
`default_nettype none

module lru_contact_bucket
  import lcb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // command channel
  input  wire logic                 req_valid,
  output logic                      req_stall,
  input  wire logic [2:0]           cmd,
  input  wire logic [KEY_BITS-1:0]  node_key,
  input  wire logic [EP_BITS-1:0]   endpoint,
  // result channel
  output logic                      rsp_valid,
  input  wire logic                 rsp_stall,
  output logic [1:0]                status,
  output logic [KEY_BITS-1:0]       found_key,
  output logic [EP_BITS-1:0]        found_endpoint,
  output logic [CNT_W-1:0]          entry_count,
  output logic                      key_in_range,
  // configuration channel
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [KEY_BITS-1:0]  cfg_data
);

  state_t state, state_next;

  logic [CNT_W-1:0]    capacity;
  logic [KEY_BITS-1:0] range_low;
  logic [KEY_BITS-1:0] range_high;

  logic [CNT_W-1:0]    occ, occ_next;
  logic [CNT_W-1:0]    ptr, ptr_next;
  logic [CNT_W-1:0]    cnt, cnt_next;
  logic                sh_up, sh_up_next;
  logic                pend, pend_next;
  logic [SLOT_W-1:0]   pend_idx, pend_idx_next;

  cmd_t                cmd_q;
  logic [KEY_BITS-1:0] key_q;
  logic [EP_BITS-1:0]  ep_q;
  logic                in_range_q;

  status_t             res_status, res_status_next;
  logic [KEY_BITS-1:0] res_key, res_key_next;
  logic [EP_BITS-1:0]  res_ep, res_ep_next;

  logic                rd_en, wr_en;
  logic [SLOT_W-1:0]   rd_addr, wr_addr;
  logic [ENTRY_W-1:0]  wr_data, rd_data;
  logic [KEY_BITS-1:0] rd_key;
  logic [EP_BITS-1:0]  rd_ep;

  logic                req_accept, rsp_free, load_rsp;
  logic [CNT_W-1:0]    cap_eff, occ_m1, pos_ext;
  logic                hit, scan_end, full, pos_zero, pos_last, shift_done;

  lcb_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_SLOTS)
  ) u_slots (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign rd_key = rd_data[ENTRY_W-1 -: KEY_BITS];
  assign rd_ep  = rd_data[EP_BITS-1:0];

  assign req_stall  = (state != ST_IDLE);
  assign req_accept = req_valid && !req_stall;
  assign rsp_free   = !rsp_valid || !rsp_stall;
  assign cfg_ready  = 1'b1;

  assign cap_eff    = (capacity > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : capacity;
  assign occ_m1     = occ - CNT_W'(1);
  assign pos_ext    = {1'b0, pend_idx};
  assign hit        = pend && (rd_key == key_q);
  assign scan_end   = pend && (pos_ext == occ_m1);
  assign full       = (occ >= cap_eff);
  assign pos_zero   = (pend_idx == '0);
  assign pos_last   = (pos_ext == occ_m1);
  assign shift_done = pend && (cnt == '0);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity   <= CAPACITY_RESET;
      range_low  <= '0;
      range_high <= '1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CAPACITY:   capacity   <= cfg_data[CNT_W-1:0];
        REG_RANGE_LOW:  range_low  <= cfg_data;
        REG_RANGE_HIGH: range_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_accept) begin
          case (cmd_t'(cmd)) inside
            CMD_ADD: begin
              if (occ != '0) state_next = ST_SCAN;
              else if (cap_eff == '0) state_next = ST_DONE;
              else state_next = ST_FRONT;
            end
            CMD_REMOVE, CMD_LOOKUP: state_next = (occ == '0) ? ST_DONE : ST_SCAN;
            CMD_OLDEST: state_next = (occ == '0) ? ST_DONE : ST_OLDEST;
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        if (hit) begin
          case (cmd_q)
            CMD_ADD:    state_next = pos_zero ? ST_FRONT : ST_SHIFT;
            CMD_REMOVE: state_next = pos_last ? ST_DONE : ST_SHIFT;
            default:    state_next = ST_DONE;
          endcase
        end else if (scan_end) begin
          state_next = (cmd_q == CMD_ADD && !full) ? ST_SHIFT : ST_DONE;
        end
      end
      ST_OLDEST: state_next = ST_DONE;
      ST_SHIFT: begin
        if (shift_done) state_next = sh_up ? ST_DONE : ST_FRONT;
      end
      ST_FRONT: state_next = ST_DONE;
      ST_DONE: begin
        if (rsp_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    occ_next        = occ;
    ptr_next        = ptr;
    cnt_next        = cnt;
    sh_up_next      = sh_up;
    pend_next       = 1'b0;
    pend_idx_next   = pend_idx;
    res_status_next = res_status;
    res_key_next    = res_key;
    res_ep_next     = res_ep;
    rd_en           = 1'b0;
    rd_addr         = ptr[SLOT_W-1:0];
    wr_en           = 1'b0;
    wr_addr         = '0;
    wr_data         = {key_q, ep_q};
    load_rsp        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (req_accept) begin
          res_status_next = STAT_MISS;
          res_key_next    = '0;
          res_ep_next     = '0;
          ptr_next        = '0;
          case (cmd_t'(cmd))
            CMD_ADD: begin
              if (occ == '0) begin
                if (cap_eff == '0) begin
                  res_status_next = STAT_FULL;
                end else begin
                  res_status_next = STAT_OK;
                  occ_next        = CNT_W'(1);
                end
              end
            end
            CMD_OLDEST: begin
              if (occ != '0) begin
                rd_en   = 1'b1;
                rd_addr = occ_m1[SLOT_W-1:0];
              end
            end
            CMD_RANGE: res_status_next = STAT_OK;
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (hit) begin
          res_status_next = STAT_OK;
          case (cmd_q)
            CMD_LOOKUP: begin
              res_key_next = rd_key;
              res_ep_next  = rd_ep;
            end
            CMD_REMOVE: begin
              // close the gap: move slots behind the match one place forward
              occ_next   = occ_m1;
              ptr_next   = pos_ext + CNT_W'(1);
              cnt_next   = occ_m1 - pos_ext;
              sh_up_next = 1'b1;
            end
            CMD_ADD: begin
              // push slots in front of the match one place back
              ptr_next   = pos_ext - CNT_W'(1);
              cnt_next   = pos_ext;
              sh_up_next = 1'b0;
            end
            default: ;
          endcase
        end else if (scan_end) begin
          if (cmd_q == CMD_ADD) begin
            if (full) begin
              res_status_next = STAT_FULL;
            end else begin
              res_status_next = STAT_OK;
              occ_next        = occ + CNT_W'(1);
              ptr_next        = occ_m1;
              cnt_next        = occ;
              sh_up_next      = 1'b0;
            end
          end
        end else if (ptr < occ) begin
          rd_en         = 1'b1;
          pend_next     = 1'b1;
          pend_idx_next = ptr[SLOT_W-1:0];
          ptr_next      = ptr + CNT_W'(1);
        end
      end
      ST_OLDEST: begin
        res_status_next = STAT_OK;
        res_key_next    = rd_key;
        res_ep_next     = rd_ep;
      end
      ST_SHIFT: begin
        if (pend) begin
          wr_en   = 1'b1;
          wr_addr = sh_up ? (pend_idx - SLOT_W'(1)) : (pend_idx + SLOT_W'(1));
          wr_data = rd_data;
        end
        if (cnt != '0) begin
          rd_en         = 1'b1;
          pend_next     = 1'b1;
          pend_idx_next = ptr[SLOT_W-1:0];
          ptr_next      = sh_up ? (ptr + CNT_W'(1)) : (ptr - CNT_W'(1));
          cnt_next      = cnt - CNT_W'(1);
        end
      end
      ST_FRONT: begin
        wr_en = 1'b1;
      end
      ST_DONE: begin
        load_rsp = rsp_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      occ       <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
      pend  <= pend_next;
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr        <= ptr_next;
    cnt        <= cnt_next;
    sh_up      <= sh_up_next;
    pend_idx   <= pend_idx_next;
    res_status <= res_status_next;
    res_key    <= res_key_next;
    res_ep     <= res_ep_next;
    if (req_accept) begin
      cmd_q      <= cmd_t'(cmd);
      key_q      <= node_key;
      ep_q       <= endpoint;
      in_range_q <= (range_low <= node_key) && (node_key <= range_high);
    end
    if (load_rsp) begin
      status         <= res_status;
      found_key      <= res_key;
      found_endpoint <= res_ep;
      entry_count    <= occ;
      key_in_range   <= in_range_q;
    end
  end

  a_occ_bound : assert property (@(posedge clk) disable iff (rst)
    occ <= CNT_W'(MAX_SLOTS))
    else $error("occupancy above slot count");

  a_write_phase : assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == ST_SHIFT || state == ST_FRONT))
    else $error("slot RAM written outside shift or front write");

  // a forward shift after remove may read the slot just vacated
  a_read_bound : assert property (@(posedge clk) disable iff (rst)
    rd_en |-> ({1'b0, rd_addr} <= occ))
    else $error("slot read beyond occupancy");

  a_front_done : assert property (@(posedge clk) disable iff (rst)
    (state == ST_FRONT) |=> (state == ST_DONE))
    else $error("front write not followed by result");

  a_rsp_source : assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == ST_DONE))
    else $error("result word raised outside done state");

endmodule

`default_nettype wire
